// ===== rtl/pidc_pkg.sv =====
// Shared types, widths and helpers for the PID controller step block.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int MEAS_W  = 16;
  localparam int DIFF_W  = 17;   // difference of two 16-bit values
  localparam int GAIN_W  = 32;
  localparam int LIM_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = GAIN_W + DIFF_W;
  localparam int INTEG_W = 40;
  localparam int ACC_W   = PROD_W + 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_LIM_LO   = 3'd3;
  localparam logic [2:0] REG_LIM_HI   = 3'd4;
  localparam logic [2:0] REG_PROP_ERR = 3'd5;

  localparam logic signed [LIM_W-1:0] LIM_LO_RST = 16'sd0;
  localparam logic signed [LIM_W-1:0] LIM_HI_RST = 16'sd255;

  typedef struct packed {
    logic signed [DIFF_W-1:0] err;
    logic signed [DIFF_W-1:0] dmeas;
  } item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [LIM_W-1:0]  lim_lo;
    logic signed [LIM_W-1:0]  lim_hi;
    logic                     prop_on_error;
  } cfg_t;

  // Upper limit tested first; if lo > hi, v above hi gives hi, else lo.
  function automatic logic signed [ACC_W-1:0] clamp_q(
    input logic signed [ACC_W-1:0] v,
    input logic signed [LIM_W-1:0] lo,
    input logic signed [LIM_W-1:0] hi
  );
    logic signed [ACC_W-1:0] hi_q;
    logic signed [ACC_W-1:0] lo_q;
    hi_q = {{(ACC_W-LIM_W-FRAC_W){hi[LIM_W-1]}}, hi, {FRAC_W{1'b0}}};
    lo_q = {{(ACC_W-LIM_W-FRAC_W){lo[LIM_W-1]}}, lo, {FRAC_W{1'b0}}};
    if (v > hi_q) begin
      clamp_q = hi_q;
    end else if (v < lo_q) begin
      clamp_q = lo_q;
    end else begin
      clamp_q = v;
    end
  endfunction

endpackage

// ===== rtl/pidc_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0] paddr,
  input  logic [pidc_pkg::DATA_W-1:0] pwdata,
  output logic [pidc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output pidc_pkg::cfg_t             cfg
);
  import pidc_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp            <= '0;
      cfg_r.ki            <= '0;
      cfg_r.kd            <= '0;
      cfg_r.lim_lo        <= LIM_LO_RST;
      cfg_r.lim_hi        <= LIM_HI_RST;
      cfg_r.prop_on_error <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:   cfg_r.kp            <= pwdata;
        REG_GAIN_I:   cfg_r.ki            <= pwdata;
        REG_GAIN_D:   cfg_r.kd            <= pwdata;
        REG_LIM_LO:   cfg_r.lim_lo        <= pwdata[LIM_W-1:0];
        REG_LIM_HI:   cfg_r.lim_hi        <= pwdata[LIM_W-1:0];
        REG_PROP_ERR: cfg_r.prop_on_error <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:   prdata = cfg_r.kp;
      REG_GAIN_I:   prdata = cfg_r.ki;
      REG_GAIN_D:   prdata = cfg_r.kd;
      REG_LIM_LO:   prdata = DATA_W'(cfg_r.lim_lo);
      REG_LIM_HI:   prdata = DATA_W'(cfg_r.lim_hi);
      REG_PROP_ERR: prdata = DATA_W'(cfg_r.prop_on_error);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/pidc_front.sv =====
// Front end: takes a request, forms error and measurement change, and
// tracks the previous measurement. Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [pidc_pkg::MEAS_W-1:0] in_measurement,
  input  logic signed [pidc_pkg::MEAS_W-1:0] in_setpoint,
  input  logic                              q_full,
  output logic                              in_stall,
  output logic                              push,
  output pidc_pkg::item_t                   push_item
);
  import pidc_pkg::*;

  logic signed [MEAS_W-1:0] prev_meas_r;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign push_item.err   = DIFF_W'(in_setpoint) - DIFF_W'(in_measurement);
  assign push_item.dmeas = DIFF_W'(in_measurement) - DIFF_W'(prev_meas_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_meas_r <= '0;
    end else if (push) begin
      prev_meas_r <= in_measurement;
    end
  end

endmodule

// ===== rtl/pidc_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pidc_pkg::item_t push_item,
  output logic            full,
  output logic            q_valid,
  output pidc_pkg::item_t q_item,
  input  logic            pop
);
  import pidc_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/pidc_back.sv =====
// Back end: products, integral update with clamp, drive sum with clamp,
// truncation to integer and the output register. Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pidc_pkg::cfg_t                     cfg,
  input  logic                               q_valid,
  input  pidc_pkg::item_t                    q_item,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pidc_pkg::MEAS_W-1:0] out_drive
);
  import pidc_pkg::*;

  localparam logic [INTEG_W-1:0] FRAC_MASK =
    {{(INTEG_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

  // stage 1: products
  logic                     v1_r;
  logic signed [PROD_W-1:0] kp_e_r, ki_e_r, kp_dm_r, kd_dm_r;
  // stage 2: integral
  logic                      v2_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W-1:0] sum2_r;
  logic signed [PROD_W-1:0]  p2_r, d2_r;
  // stage 3: clamped drive, Q.16
  logic                      v3_r;
  logic signed [INTEG_W-1:0] q3_r;
  // output
  logic                      vo_r;
  logic signed [MEAS_W-1:0]  drive_r;

  logic rdy_o, rdy3, rdy2, rdy1;
  logic signed [ACC_W-1:0]   integ_raw, drive_raw;
  logic signed [INTEG_W-1:0] integ_nxt, q3_nxt;
  logic [INTEG_W-1:0]        round_up;
  logic signed [MEAS_W-1:0]  drive_nxt;

  assign rdy_o = !vo_r || !out_stall;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign pop   = q_valid && rdy1;

  assign out_valid = vo_r;
  assign out_drive = drive_r;

  // P on measurement moves the proportional part into the integral sum
  assign integ_raw = ACC_W'(integ_r) + ACC_W'(ki_e_r)
                   - (cfg.prop_on_error ? ACC_W'(0) : ACC_W'(kp_dm_r));
  assign integ_nxt = INTEG_W'(clamp_q(integ_raw, cfg.lim_lo, cfg.lim_hi));

  assign drive_raw = ACC_W'(p2_r) + ACC_W'(sum2_r) - ACC_W'(d2_r);
  assign q3_nxt    = INTEG_W'(clamp_q(drive_raw, cfg.lim_lo, cfg.lim_hi));

  // truncate toward zero: bias negatives by one LSB short of an integer
  assign round_up  = q3_r[INTEG_W-1] ? FRAC_MASK : '0;
  always_comb begin
    logic [INTEG_W-1:0] biased;
    biased    = q3_r + round_up;
    drive_nxt = biased[FRAC_W+MEAS_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vo_r    <= 1'b0;
      integ_r <= '0;
    end else begin
      if (rdy1)  v1_r <= q_valid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
      if (v1_r && rdy2) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kp_e_r  <= PROD_W'(cfg.kp) * PROD_W'(q_item.err);
      ki_e_r  <= PROD_W'(cfg.ki) * PROD_W'(q_item.err);
      kp_dm_r <= PROD_W'(cfg.kp) * PROD_W'(q_item.dmeas);
      kd_dm_r <= PROD_W'(cfg.kd) * PROD_W'(q_item.dmeas);
    end
    if (v1_r && rdy2) begin
      sum2_r <= integ_nxt;
      p2_r   <= cfg.prop_on_error ? kp_e_r : '0;
      d2_r   <= kd_dm_r;
    end
    if (v2_r && rdy3) begin
      q3_r <= q3_nxt;
    end
    if (v3_r && rdy_o) begin
      drive_r <= drive_nxt;
    end
  end

endmodule

// ===== rtl/pid_controller_step.sv =====
// PID controller step, derivative on measurement, fixed-point gains.
// Channels: input request (in_valid / in_stall, in_measurement, in_setpoint)
// and result request (out_valid / out_stall, out_drive), one drive per input.
// A request is taken at a rising edge with valid high and stall low.
// Configuration: APB-style port, registers at byte address 4*index:
//   0 kp, 1 ki, 2 kd (signed Q16.16), 3 low limit, 4 high limit, 5 P-on-error.
// A request taken at a rising edge shows its drive on out_valid after the
// queue, products, integral, drive clamp and truncation/output registers.
// Throughput: one request per cycle while out_stall is low, set by the
// integral add-and-clamp loop, which feeds integ_r back into itself.
// in_stall rises only while the two-entry queue is full; a stalled receiver
// backs up the back-end pipeline, then the queue, then the input.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the previous
// measurement and the integral sum, and loads the register reset values.
// Depends on pidc_pkg, pidc_regs, pidc_front, pidc_queue, pidc_back.
`timescale 1ns / 1ps

module pid_controller_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pidc_pkg::MEAS_W-1:0] in_measurement,
  input  logic signed [pidc_pkg::MEAS_W-1:0] in_setpoint,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pidc_pkg::MEAS_W-1:0] out_drive,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]        paddr,
  input  logic [pidc_pkg::DATA_W-1:0]        pwdata,
  output logic [pidc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import pidc_pkg::*;

  cfg_t  cfg;
  item_t push_item, q_item;
  logic  push, q_full, q_valid, pop;

  pidc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_measurement (in_measurement),
    .in_setpoint    (in_setpoint),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .push_item      (push_item)
  );

  pidc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  pidc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_drive (out_drive)
  );

endmodule
